>>> hdl/utf8wd_pkg.sv
// utf8wd_pkg: shared types, constants and the lead-byte length function
// for the utf-8 to wide decoder; no dependencies
package utf8wd_pkg;

    localparam int OUT_DEPTH   = 4;   // result queue entries, at least MAX_RESULTS
    localparam int MAX_RESULTS = 2;   // results one item can cause

    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE  = 8'hF0;

    localparam logic [20:0] SURR_BASE   = 21'h10000;
    localparam logic [20:0] SURR_HIGH   = 21'h0D800;
    localparam logic [20:0] SURR_LOW    = 21'h0DC00;

    // sequence lengths
    localparam logic [2:0]  LEN_BAD = 3'd0;
    localparam logic [2:0]  LEN_1   = 3'd1;
    localparam logic [2:0]  LEN_2   = 3'd2;
    localparam logic [2:0]  LEN_3   = 3'd3;
    localparam logic [2:0]  LEN_4   = 3'd4;

    typedef struct packed {
        logic [20:0] code_unit;
        logic        end_of_string;
        logic        no_unit;
    } t_result;

    typedef struct packed {
        logic [1:0]                     num;  // results produced, 0 to 2
        t_result [MAX_RESULTS-1:0]      res;  // res[0] goes out first
    } t_step;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if (c < ASCII_LIMIT) begin
            len = LEN_1;
        end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
            len = LEN_2;
        end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
            len = LEN_3;
        end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
            len = LEN_4;
        end else begin
            len = LEN_BAD;
        end
        return len;
    endfunction

endpackage

>>> hdl/utf8wd_decode.sv
// utf8wd_decode: combinational decode of one byte against the open sequence
// depends on utf8wd_pkg
module utf8wd_decode (
    input  logic [1:0]      i_pend_cnt,
    input  logic [2:0][7:0] i_pend,
    input  logic [7:0]      i_byte,
    input  logic            i_final,
    input  logic            i_mode,
    output utf8wd_pkg::t_step o_step,
    output logic [1:0]      o_next_cnt,
    output logic            o_store
);

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  n;
    logic [2:0]  need;
    logic [2:0]  len1;
    logic        full;
    logic        do_run;
    logic [20:0] cp;
    logic [20:0] v;
    logic        split;
    logic [20:0] cp2;

    // assembled sequence: buffered bytes then the new one
    assign b0 = (i_pend_cnt == 2'd0) ? i_byte : i_pend[0];
    assign b1 = (i_pend_cnt == 2'd1) ? i_byte : i_pend[1];
    assign b2 = (i_pend_cnt == 2'd2) ? i_byte : i_pend[2];
    assign b3 = i_byte;
    assign n  = {1'b0, i_pend_cnt} + 3'd1;

    assign need   = utf8wd_pkg::lead_length(b0);
    assign len1   = utf8wd_pkg::lead_length(b1);
    assign full   = (need <= n);
    assign do_run = i_final || full;

    assign o_next_cnt = do_run ? 2'd0 : n[1:0];
    assign o_store    = !do_run;

    always_comb begin
        case (need)
            utf8wd_pkg::LEN_1: cp = {13'b0, b0};
            utf8wd_pkg::LEN_2: cp = {10'b0, b0[4:0], b1[5:0]};
            utf8wd_pkg::LEN_3: cp = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
            default:           cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        endcase
    end

    assign v     = cp - utf8wd_pkg::SURR_BASE;
    assign split = i_mode && (cp >= utf8wd_pkg::SURR_BASE);
    // two-byte sequence starting after a dropped lead
    assign cp2   = {10'b0, b1[4:0], b2[5:0]};

    always_comb begin
        o_step = '0;
        if (do_run) begin
            if (full) begin
                if (need != utf8wd_pkg::LEN_BAD) begin
                    if (split) begin
                        o_step.res[0].code_unit = utf8wd_pkg::SURR_HIGH | {10'b0, v[20:10]};
                        o_step.res[1].code_unit = utf8wd_pkg::SURR_LOW | {11'b0, v[9:0]};
                        o_step.num = 2'd2;
                    end else begin
                        o_step.res[0].code_unit = cp;
                        o_step.num = 2'd1;
                    end
                end
            end else begin
                // cut short at end of string: lead dropped, rest decoded as leads
                case (n)
                    3'd2: begin
                        if (!b1[7]) begin
                            o_step.res[0].code_unit = {13'b0, b1};
                            o_step.num = 2'd1;
                        end
                    end
                    3'd3: begin
                        if (len1 == utf8wd_pkg::LEN_1) begin
                            o_step.res[0].code_unit = {13'b0, b1};
                            if (!b2[7]) begin
                                o_step.res[1].code_unit = {13'b0, b2};
                                o_step.num = 2'd2;
                            end else begin
                                o_step.num = 2'd1;
                            end
                        end else if (len1 == utf8wd_pkg::LEN_2) begin
                            o_step.res[0].code_unit = cp2;
                            o_step.num = 2'd1;
                        end else if (!b2[7]) begin
                            o_step.res[0].code_unit = {13'b0, b2};
                            o_step.num = 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_final) begin
                case (o_step.num)
                    2'd0: begin
                        o_step.res[0].end_of_string = 1'b1;
                        o_step.res[0].no_unit       = 1'b1;
                        o_step.num = 2'd1;
                    end
                    2'd1:    o_step.res[0].end_of_string = 1'b1;
                    default: o_step.res[1].end_of_string = 1'b1;
                endcase
            end
        end
    end

endmodule

>>> hdl/utf8wd_out_fifo.sv
// utf8wd_out_fifo: result queue taking up to two results per cycle, one out
// depends on utf8wd_pkg
module utf8wd_out_fifo #(
    parameter int DEPTH = utf8wd_pkg::OUT_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utf8wd_pkg::t_step   i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output utf8wd_pkg::t_result o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utf8wd_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wp, n_rp, wp1, wp2;
    logic [CW-1:0] n_count;
    logic          pop;

    assign wp1 = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign wp2 = (wp1 == PW'(DEPTH - 1)) ? '0 : wp1 + 1'b1;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(DEPTH - utf8wd_pkg::MAX_RESULTS));
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;

    always_comb begin
        case (i_push.num)
            2'd0:    n_wp = r_wp;
            2'd1:    n_wp = wp1;
            default: n_wp = wp2;
        endcase
        n_rp    = pop ? ((r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1) : r_rp;
        n_count = r_count + CW'(i_push.num) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wp] <= i_push.res[0];
        end
        if (i_push.num == 2'd2) begin
            r_mem[wp1] <= i_push.res[1];
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room)
        else $error("result pushed without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_pop_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.num == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("result queue count did not follow a pop");

endmodule

>>> hdl/utf8_to_wide_decoder.sv
// utf8_to_wide_decoder: top level, input register, open-sequence state,
// mode register; depends on utf8wd_pkg, utf8wd_decode, utf8wd_out_fifo

// Takes a utf-8 string one byte per item and delivers utf-16 code units
// (mode register 1, the reset value) or whole 21-bit code points (mode 0).
// Each accepted item lands in an input register; once the queue has room
// for two results it is decoded against the bytes of the open sequence
// and its results, none to two, go into a small result queue that drives
// the output ports. An item is taken every cycle while the queue has room
// for two results, so the block sustains one item per cycle; the first
// result passes the input register and then the queue on its way out.
// The queue drains one result a cycle, so a stream of items that yield
// surrogate pairs fills it and holds off input. Continuation bytes are
// not checked, overlong forms and surrogates pass through, and bytes that
// are not valid leads are dropped. When the final byte cuts a sequence
// short, its lead is dropped and the bytes after it are decoded again as
// leads. The last result of a string carries end_of_string; if the string
// leaves nothing to send, an end-only result with no_unit set and code_unit
// zero is sent. The user must write the mode register through i_cfg_we and
// i_cfg_wdata only while the block is idle; the block does not enforce it.
module utf8_to_wide_decoder #(
    parameter int OUT_DEPTH = utf8wd_pkg::OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // mode register
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_final,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_unit,
    output logic        o_end_of_string,
    output logic        o_no_unit
);

    // mode register
    logic r_utf16_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;
    logic       n_in_valid;

    // open sequence: buffered lead and continuation bytes
    logic [2:0][7:0] r_pend;
    logic [1:0]      r_pend_cnt;

    logic                in_acc;
    logic                proc;
    logic                room;
    utf8wd_pkg::t_step   dec_step;
    utf8wd_pkg::t_step   push;
    logic [1:0]          dec_next_cnt;
    logic                dec_store;
    utf8wd_pkg::t_result head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf16_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_utf16_mode <= i_cfg_wdata;
        end
    end

    // the held item is decoded once the queue can take two results
    assign proc       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || proc;
    assign in_acc     = i_in_valid && o_in_ready;
    assign n_in_valid = in_acc ? 1'b1 : (proc ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte  <= i_in_byte;
            r_in_final <= i_is_final;
        end
    end

    utf8wd_decode u_decode (
        .i_pend_cnt (r_pend_cnt),
        .i_pend     (r_pend),
        .i_byte     (r_in_byte),
        .i_final    (r_in_final),
        .i_mode     (r_utf16_mode),
        .o_step     (dec_step),
        .o_next_cnt (dec_next_cnt),
        .o_store    (dec_store)
    );

    // open sequence advances only when the held item is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
        end else if (proc) begin
            r_pend_cnt <= dec_next_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && dec_store) begin
            r_pend[r_pend_cnt] <= r_in_byte;
        end
    end

    always_comb begin
        push = dec_step;
        if (!proc) begin
            push.num = 2'd0;
        end
    end

    utf8wd_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    assign o_code_unit     = head.code_unit;
    assign o_end_of_string = head.end_of_string;
    assign o_no_unit       = head.no_unit;

    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_final) |=> (r_pend_cnt == 2'd0))
        else $error("sequence left open after final byte");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_final) |-> (dec_step.num != 2'd0))
        else $error("final byte produced no result");

    a_open_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt != 2'd0) |->
        (utf8wd_pkg::lead_length(r_pend[0]) > {1'b0, r_pend_cnt}))
        else $error("open sequence not headed by an unfinished lead");

    a_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_unit) |-> (o_end_of_string && o_code_unit == 21'd0))
        else $error("end-only result malformed");

endmodule
